### sv/assert_macros.svh
// Assertion macros shared by the sieve block.
// Included by modules that check their own control logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### sv/lsep_pkg.sv
// Shared types, codes and helpers for the linear sieve exponent product block.
// No dependencies.
package lsep_pkg;

    // widths of the fixed result fields
    localparam int EPW = 6;   // exponent product, saturated
    localparam int CW  = 5;   // smallest-prime exponent as stored
    localparam int LEW = 4;   // smallest-prime exponent, reported
    localparam int PCOUTW = 13;

    // request kinds
    localparam logic MODE_BUILD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_BUILT = 2'd0;
    localparam logic [1:0] STATUS_OK    = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // start request toward the sequencer
    typedef struct packed {
        logic go;
        logic mode;
    } seq_req_t;

    // completion from the sequencer
    typedef struct packed {
        logic            done;
        logic            composite;
        logic [EPW-1:0]  exp_prod;
        logic [LEW-1:0]  low_exp;
    } seq_rsp_t;

    // rest * c saturated to 63
    function automatic logic [EPW-1:0] sat_mul(input logic [EPW-1:0] rest,
                                               input logic [CW-1:0] c);
        logic [EPW+CW-1:0] pr;
        pr = {{CW{1'b0}}, rest} * {{EPW{1'b0}}, c};
        sat_mul = (pr > (EPW+CW)'(63)) ? EPW'(63) : pr[EPW-1:0];
    endfunction

endpackage

### sv/lsep_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lsep_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### sv/lsep_seq.sv
// Sieve sequencer: clear pass, linear sieve and table lookup over shared RAMs.
// Depends on lsep_pkg, lsep_ram and assert_macros.svh.
`include "assert_macros.svh"
module lsep_seq #(
    parameter int MAX_N      = 65536,
    parameter int MAX_PRIMES = 8192
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsep_pkg::seq_req_t                req,
    input  logic [$clog2(MAX_N)-1:0]          idx,
    input  logic [$clog2(MAX_N):0]            lim,
    output lsep_pkg::seq_rsp_t                rsp,
    output logic [lsep_pkg::PCOUTW-1:0]       prime_total
);

    localparam int NW  = $clog2(MAX_N);
    localparam int LW  = NW + 1;
    localparam int PW  = $clog2(MAX_PRIMES);
    localparam int PCW = $clog2(MAX_PRIMES + 1);
    localparam int EPW = lsep_pkg::EPW;
    localparam int CW  = lsep_pkg::CW;
    // table word: {lpf, c, rest, composite}
    localparam int WW  = NW + CW + EPW + 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_CLR  = 10'b0000000010,
        S_IRD  = 10'b0000000100,
        S_ICHK = 10'b0000001000,
        S_JRD  = 10'b0000010000,
        S_JMUL = 10'b0000100000,
        S_JCHK = 10'b0001000000,
        S_QRD  = 10'b0010000000,
        S_QOUT = 10'b0100000000,
        S_DONE = 10'b1000000000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [LW-1:0]     i_reg, i_next;
    logic [PCW-1:0]    j_reg, j_next;
    logic [PCW-1:0]    cnt_reg, cnt_next;
    logic [LW-1:0]     lim_reg, lim_next;
    logic [NW-1:0]     idx_reg, idx_next;
    logic [EPW-1:0]    rest_reg, rest_next;
    logic [CW-1:0]     c_reg, c_next;
    logic [EPW-1:0]    rmul_reg, rmul_next;
    logic [NW-1:0]     lpf_reg, lpf_next;
    logic [NW-1:0]     p_reg, p_next;
    logic [LW+NW-1:0]  prod_reg, prod_next;

    // RAM ports
    logic              t_we;
    logic [NW-1:0]     t_waddr, t_raddr;
    logic [WW-1:0]     t_wdata, t_rdata;
    logic              p_we;
    logic [PW-1:0]     p_waddr, p_raddr;
    logic [NW-1:0]     p_wdata, p_rdata;

    // fields of the word just read
    logic              rd_comp;
    logic [EPW-1:0]    rd_rest;
    logic [CW-1:0]     rd_c;
    logic [NW-1:0]     rd_lpf;
    logic [EPW-1:0]    rest_sel;
    logic [CW-1:0]     c_sel;
    logic [LW-1:0]     i_inc;

    assign rd_comp = t_rdata[0];
    assign rd_rest = t_rdata[EPW:1];
    assign rd_c    = t_rdata[EPW+CW:EPW+1];
    assign rd_lpf  = t_rdata[WW-1:EPW+CW+1];
    assign i_inc   = i_reg + LW'(1);

    lsep_ram #(.DW(WW), .DEPTH(MAX_N)) u_table (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    lsep_ram #(.DW(NW), .DEPTH(MAX_PRIMES)) u_primes (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        lim_next   = lim_reg;
        idx_next   = idx_reg;
        rest_next  = rest_reg;
        c_next     = c_reg;
        rmul_next  = rmul_reg;
        lpf_next   = lpf_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        t_we       = 1'b0;
        t_waddr    = i_reg[NW-1:0];
        t_wdata    = '0;
        t_raddr    = i_reg[NW-1:0];
        p_we       = 1'b0;
        p_waddr    = cnt_reg[PW-1:0];
        p_wdata    = i_reg[NW-1:0];
        p_raddr    = j_reg[PW-1:0];
        rest_sel   = rd_rest;
        c_sel      = rd_c;
        rsp        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.go)
                begin
                    lim_next = lim;
                    idx_next = idx;
                    if (req.mode == lsep_pkg::MODE_QUERY)
                    begin
                        state_next = S_QRD;
                    end
                    else
                    begin
                        cnt_next = '0;
                        i_next   = '0;
                        state_next = (lim < LW'(2)) ? S_DONE : S_CLR;
                    end
                end
            end

            // zero every entry below the limit; entry one gets rest 1, c 0
            S_CLR:
            begin
                t_we    = 1'b1;
                t_wdata = (i_reg == LW'(1)) ? WW'(2) : '0;
                if (i_inc >= lim_reg)
                begin
                    i_next     = LW'(2);
                    state_next = (lim_reg > LW'(2)) ? S_IRD : S_DONE;
                end
                else
                begin
                    i_next = i_inc;
                end
            end

            S_IRD:
            begin
                state_next = S_ICHK;
            end

            // classify i, record it if prime and the prime RAM has room
            S_ICHK:
            begin
                if (!rd_comp)
                begin
                    rest_sel = EPW'(1);
                    c_sel    = CW'(1);
                    lpf_next = i_reg[NW-1:0];
                    t_we     = 1'b1;
                    t_wdata  = {i_reg[NW-1:0], CW'(1), EPW'(1), 1'b0};
                    if (cnt_reg < PCW'(MAX_PRIMES))
                    begin
                        p_we     = 1'b1;
                        cnt_next = cnt_reg + PCW'(1);
                    end
                end
                else
                begin
                    lpf_next = rd_lpf;
                end
                rest_next = rest_sel;
                c_next    = c_sel;
                rmul_next = lsep_pkg::sat_mul(rest_sel, c_sel);
                j_next    = '0;
                if (cnt_next == '0)
                begin
                    i_next     = i_inc;
                    state_next = (i_inc >= lim_reg) ? S_DONE : S_IRD;
                end
                else
                begin
                    state_next = S_JRD;
                end
            end

            S_JRD:
            begin
                state_next = S_JMUL;
            end

            // shared multiplier: m = i * p
            S_JMUL:
            begin
                p_next     = p_rdata;
                prod_next  = (LW+NW)'(i_reg) * (LW+NW)'(p_rdata);
                state_next = S_JCHK;
            end

            // mark m if below the limit; stop at the smallest prime of i, at the limit or after the last prime
            S_JCHK:
            begin
                if (prod_reg >= (LW+NW)'(lim_reg))
                begin
                    i_next     = i_inc;
                    state_next = (i_inc >= lim_reg) ? S_DONE : S_IRD;
                end
                else
                begin
                    t_we    = 1'b1;
                    t_waddr = prod_reg[NW-1:0];
                    if (p_reg == lpf_reg)
                    begin
                        t_wdata    = {p_reg, c_reg + CW'(1), rest_reg, 1'b1};
                        i_next     = i_inc;
                        state_next = (i_inc >= lim_reg) ? S_DONE : S_IRD;
                    end
                    else
                    begin
                        t_wdata = {p_reg, CW'(1), rmul_reg, 1'b1};
                        j_next  = j_reg + PCW'(1);
                        if (j_next >= cnt_reg)
                        begin
                            i_next     = i_inc;
                            state_next = (i_inc >= lim_reg) ? S_DONE : S_IRD;
                        end
                        else
                        begin
                            state_next = S_JRD;
                        end
                    end
                end
            end

            S_QRD:
            begin
                t_raddr    = idx_reg;
                state_next = S_QOUT;
            end

            // lookup result
            S_QOUT:
            begin
                rsp.done      = 1'b1;
                rsp.composite = rd_comp;
                rsp.exp_prod  = (rd_c == '0) ? rd_rest : lsep_pkg::sat_mul(rd_rest, rd_c);
                rsp.low_exp   = (rd_c > CW'(15)) ? lsep_pkg::LEW'(15)
                                                 : rd_c[lsep_pkg::LEW-1:0];
                state_next    = S_IDLE;
            end

            S_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign prime_total = lsep_pkg::PCOUTW'(cnt_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        lim_reg  <= lim_next;
        idx_reg  <= idx_next;
        rest_reg <= rest_next;
        c_reg    <= c_next;
        rmul_reg <= rmul_next;
        lpf_reg  <= lpf_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
    end

    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= PCW'(MAX_PRIMES))
    `ASSERT_IMPL(a_done_busy, clk, rst_n, rsp.done, state_reg != S_IDLE)
    `ASSERT_NEXT(a_mul_chk, clk, rst_n, state_reg == S_JMUL, state_reg == S_JCHK)

endmodule

### sv/linear_sieve_exponent_product_top.sv
// Top level of the linear sieve exponent product block: stream ports,
// limit register and result register. Depends on lsep_pkg, lsep_seq, assert_macros.svh.
//
// Usage:
//  - Slave stream s_*: tuser is the mode (0 build, 1 query), tdata the index.
//  - Master stream m_*: tuser is the status, tdata the result fields.
//  - cfg_*: writes the limit (always ready); write only while idle. A write
//    invalidates the tables until the next build.
//  - One request at a time: s_tready is high only while the block is idle;
//    the result is held in m_tdata/m_tuser until m_tready takes it.
//  - Query: the result passes the sequencer's read and output states (registered
//    table read) into the result register; invalid queries skip the sequencer.
//  - Build: a clearing pass over the table RAM, then per number a table read and
//    classify, plus per prime tried a prime RAM read, the shared multiplier and a
//    table RAM write; one try per composite plus at most one per number.
//  - Reset: limit returns to 65536, tables count as not built; table contents
//    are rebuilt by the next build.
//  - A stalled receiver holds the block in its output state; no new request
//    is taken until the result is delivered.
`include "assert_macros.svh"
module linear_sieve_exponent_product_top #(
    parameter int MAX_N      = 65536,
    parameter int MAX_PRIMES = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] index
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] exponent_product, [9:6] low_prime_exponent,
                                   // [10] composite, [23:11] prime_count
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data   // limit
);

    localparam int NW = $clog2(MAX_N);
    localparam int LW = NW + 1;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RUN  = 3'b010,
        T_OUT  = 3'b100
    } top_state_t;

    top_state_t          state_reg, state_next;
    logic [16:0]         limit_reg, limit_next;
    logic                built_reg, built_next;
    logic                mode_reg, mode_next;
    logic [23:0]         data_reg, data_next;
    logic [1:0]          status_reg, status_next;
    logic [LW-1:0]       lim_eff;
    logic                idx_ok;
    logic                accept;
    lsep_pkg::seq_req_t  req;
    lsep_pkg::seq_rsp_t  rsp;
    logic [lsep_pkg::PCOUTW-1:0] ptotal;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == T_IDLE);
    assign m_tvalid  = (state_reg == T_OUT);
    assign m_tdata   = data_reg;
    assign m_tuser   = status_reg;
    assign accept    = s_tvalid && s_tready;

    // effective limit, capped at the table depth
    assign lim_eff = (32'(limit_reg) > 32'(MAX_N)) ? LW'(MAX_N) : LW'(limit_reg);
    assign idx_ok  = built_reg && (s_tdata != 16'd0) && (32'(s_tdata) < 32'(lim_eff));

    lsep_seq #(.MAX_N(MAX_N), .MAX_PRIMES(MAX_PRIMES)) u_seq (
        .clk(clk), .rst_n(rst_n), .req(req),
        .idx(NW'(32'(s_tdata))), .lim(lim_eff),
        .rsp(rsp), .prime_total(ptotal)
    );

    // request handling and result register
    always_comb
    begin
        state_next  = state_reg;
        limit_next  = limit_reg;
        built_next  = built_reg;
        mode_next   = mode_reg;
        data_next   = data_reg;
        status_next = status_reg;
        req         = '0;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
            built_next = 1'b0;
        end

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    mode_next = s_tuser;
                    if (s_tuser == lsep_pkg::MODE_BUILD || idx_ok)
                    begin
                        req.go     = 1'b1;
                        req.mode   = s_tuser;
                        state_next = T_RUN;
                    end
                    else
                    begin
                        data_next   = '0;
                        status_next = lsep_pkg::STATUS_BAD;
                        state_next  = T_OUT;
                    end
                end
            end

            T_RUN:
            begin
                if (rsp.done)
                begin
                    if (mode_reg == lsep_pkg::MODE_BUILD)
                    begin
                        built_next  = 1'b1;
                        status_next = lsep_pkg::STATUS_BUILT;
                        data_next   = {ptotal, 11'd0};
                    end
                    else
                    begin
                        status_next = lsep_pkg::STATUS_OK;
                        data_next   = {13'd0, rsp.composite, rsp.low_exp, rsp.exp_prod};
                    end
                    state_next = T_OUT;
                end
            end

            T_OUT:
            begin
                if (m_tready)
                begin
                    state_next = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            limit_reg <= 17'd65536;
            built_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            limit_reg <= limit_next;
            built_reg <= built_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    `ASSERT_IMPL(a_one_side, clk, rst_n, m_tvalid, !s_tready)
    `ASSERT_IMPL(a_done_run, clk, rst_n, rsp.done, state_reg == T_RUN)
    `ASSERT_NEXT(a_build_sets, clk, rst_n,
                 state_reg == T_RUN && rsp.done && mode_reg == lsep_pkg::MODE_BUILD && !cfg_valid,
                 built_reg)

endmodule

### verif/tb_top.sv
// Self-checking testbench for linear_sieve_exponent_product_top.
// Depends on lsep_pkg and the block; a built-in sieve predictor or a typed answer checks every result.
module tb_top;

    localparam int N_TOP     = 65536;
    localparam int P_TOP     = 8192;
    localparam int WDOG_MAX  = 3000000;
    localparam int N_RANDOM  = 1850;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  exp_prod;
        logic [3:0]  low_exp;
        logic        composite;
        logic [12:0] prime_cnt;
    } answer_t;

    typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic      mode;
        int        value;   // limit for ROW_CFG, index for ROW_REQ
        bit        typed;
        answer_t   want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;

    // predictor state
    bit          composite_q[N_TOP];
    int unsigned eprod_q[N_TOP];
    int unsigned lowexp_q[N_TOP];
    int unsigned primes_q[P_TOP];
    int unsigned prime_total_q;
    bit          built_q;
    int unsigned limit_q;

    answer_t     pending_answers[$];
    row_t        directed_rows[$];
    int          n_errors = 0;
    int          n_sent;
    bit          quiet;
    int          idle_cycles = 0;

    linear_sieve_exponent_product_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int unsigned clip_limit();
        return (limit_q > N_TOP) ? N_TOP : limit_q;
    endfunction

    // linear sieve over 1 .. limit-1
    function automatic void sieve_build();
        int unsigned lim;
        int unsigned p;
        int unsigned c;
        longint unsigned m;
        lim = clip_limit();
        prime_total_q = 0;
        if (lim >= 2)
        begin
            for (int k = 0; k < lim; k++)
                composite_q[k] = 1'b0;
            eprod_q[1] = 1;
            lowexp_q[1] = 0;
        end
        for (int unsigned i = 2; i < lim; i++)
        begin
            if (!composite_q[i])
            begin
                if (prime_total_q < P_TOP)
                begin
                    primes_q[prime_total_q] = i;
                    prime_total_q++;
                end
                eprod_q[i] = 1;
                lowexp_q[i] = 1;
            end
            for (int unsigned j = 0; j < prime_total_q; j++)
            begin
                p = primes_q[j];
                m = longint'(i) * p;
                if (m >= lim)
                    break;
                composite_q[m] = 1'b1;
                if (i % p == 0)
                begin
                    c = lowexp_q[i];
                    eprod_q[m] = eprod_q[i] / ((c != 0) ? c : 1) * (c + 1);
                    lowexp_q[m] = c + 1;
                    break;
                end
                eprod_q[m] = eprod_q[i];
                lowexp_q[m] = 1;
            end
        end
        built_q = 1'b1;
    endfunction

    // expected answer for one request, updating predictor state
    function automatic answer_t sieve_answer(logic mode, int unsigned idx);
        answer_t a;
        a = '0;
        if (mode == lsep_pkg::MODE_BUILD)
        begin
            sieve_build();
            a.status = lsep_pkg::STATUS_BUILT;
            a.prime_cnt = prime_total_q[12:0];
        end
        else if (!built_q || idx == 0 || idx >= clip_limit())
            a.status = lsep_pkg::STATUS_BAD;
        else
        begin
            a.status = lsep_pkg::STATUS_OK;
            a.exp_prod = (eprod_q[idx] > 63) ? 6'd63 : eprod_q[idx][5:0];
            a.low_exp = (lowexp_q[idx] > 15) ? 4'd15 : lowexp_q[idx][3:0];
            a.composite = composite_q[idx];
        end
        return a;
    endfunction

    // one request; typed answer overrides the predicted one
    task automatic send_request(logic mode, int unsigned idx, bit typed, answer_t want);
        answer_t a;
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= idx[15:0];
        do
            @(posedge clk);
        while (!s_tready);
        a = sieve_answer(mode, idx);
        pending_answers = {pending_answers, (typed ? want : a)};
        n_sent++;
        if (!quiet && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic write_limit(int unsigned v);
        cfg_valid <= 1'b1;
        cfg_data <= v[16:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_q = v & 32'h1FFFF;
        built_q = 1'b0;
    endtask

    // sender holds off until every expected answer has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic answer_t mk(logic [1:0] st, int pc);
        answer_t a;
        a = '0;
        a.status = st;
        a.prime_cnt = pc[12:0];
        return a;
    endfunction

    function automatic void add_row(row_kind_t k, logic mode, int v, bit typed, answer_t w);
        row_t r;
        r.kind = k;
        r.mode = mode;
        r.value = v;
        r.typed = typed;
        r.want = w;
        directed_rows = {directed_rows, r};
    endfunction

    // receiver stalls at random, except in the quiet stretch
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= 12);

    // result checker
    always @(posedge clk)
    begin
        answer_t got;
        answer_t exp_a;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            got.exp_prod = m_tdata[5:0];
            got.low_exp = m_tdata[9:6];
            got.composite = m_tdata[10];
            got.prime_cnt = m_tdata[23:11];
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result with none expected: %h", $time, got);
                n_errors++;
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (got.status !== exp_a.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, exp_a.status, got.status);
                    n_errors++;
                end
                if (got.exp_prod !== exp_a.exp_prod)
                begin
                    $display("%0t: exponent_product exp %0d got %0d", $time,
                             exp_a.exp_prod, got.exp_prod);
                    n_errors++;
                end
                if (got.low_exp !== exp_a.low_exp)
                begin
                    $display("%0t: low_prime_exponent exp %0d got %0d", $time,
                             exp_a.low_exp, got.low_exp);
                    n_errors++;
                end
                if (got.composite !== exp_a.composite)
                begin
                    $display("%0t: composite flag exp %0d got %0d", $time,
                             exp_a.composite, got.composite);
                    n_errors++;
                end
                if (got.prime_cnt !== exp_a.prime_cnt)
                begin
                    $display("%0t: prime_count exp %0d got %0d", $time,
                             exp_a.prime_cnt, got.prime_cnt);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        int unsigned lim;
        int unsigned idx;
        int phase;
        n_sent = 0;
        quiet = 1'b0;
        limit_q = N_TOP;
        prime_total_q = 0;
        built_q = 1'b0;

        // directed rows: query before build, tiny and oversize limits, exponent extremes
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 5, 1, mk(lsep_pkg::STATUS_BAD, 0));
        add_row(ROW_CFG, lsep_pkg::MODE_QUERY, 0, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_BUILD, 0, 1, mk(lsep_pkg::STATUS_BUILT, 0));
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 1, 1, mk(lsep_pkg::STATUS_BAD, 0));
        add_row(ROW_CFG, lsep_pkg::MODE_QUERY, 2, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_BUILD, 65535, 1, mk(lsep_pkg::STATUS_BUILT, 0));
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 1, 0, '0);
        add_row(ROW_CFG, lsep_pkg::MODE_QUERY, 40, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_BUILD, 0, 1, mk(lsep_pkg::STATUS_BUILT, 12));
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 1, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 36, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 37, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_BUILD, 0, 1, mk(lsep_pkg::STATUS_BUILT, 12));
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 39, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 40, 1, mk(lsep_pkg::STATUS_BAD, 0));
        add_row(ROW_CFG, lsep_pkg::MODE_QUERY, 131071, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 7, 1, mk(lsep_pkg::STATUS_BAD, 0));
        add_row(ROW_REQ, lsep_pkg::MODE_BUILD, 0, 1, mk(lsep_pkg::STATUS_BUILT, 6542));
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 0, 1, mk(lsep_pkg::STATUS_BAD, 0));
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 65535, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 32768, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 64, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 55440, 0, '0);
        add_row(ROW_REQ, lsep_pkg::MODE_QUERY, 65521, 0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                drain();
                write_limit(directed_rows[r].value);
            end
            else
                send_request(directed_rows[r].mode, directed_rows[r].value,
                             directed_rows[r].typed, directed_rows[r].want);
        end

        // random phases: new limit, build, then mostly in-range queries
        phase = 0;
        while (n_sent < N_RANDOM)
        begin
            drain();
            quiet = (phase == 3);
            case ($urandom_range(0, 19))
                0:       lim = $urandom_range(0, 1);
                1:       lim = $urandom_range(2, 20);
                default: lim = $urandom_range(2, 2500);
            endcase
            write_limit(lim);
            if ($urandom_range(0, 2) == 0)
                send_request(lsep_pkg::MODE_QUERY, $urandom_range(0, 65535), 0, '0);
            send_request(lsep_pkg::MODE_BUILD, $urandom_range(0, 65535), 0, '0);
            repeat ($urandom_range(80, 200))
            begin
                case ($urandom_range(0, 9))
                    0:       idx = 0;
                    1:       idx = $urandom_range(lim < 2 ? 0 : lim, 65535);
                    2:       idx = $urandom_range(0, 65535);
                    default: idx = (lim >= 2) ? $urandom_range(1, lim - 1) : 1;
                endcase
                if ($urandom_range(0, 59) == 0)
                    send_request(lsep_pkg::MODE_BUILD, idx, 0, '0);
                else
                    send_request(lsep_pkg::MODE_QUERY, idx, 0, '0);
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
